FILE: rtl/median_of_sample_set_assert.svh
// ----------------------------------------------------------------------------
// median_of_sample_set_assert.svh
// Assertion macros for the median block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_OF_SAMPLE_SET_ASSERT_SVH
`define MEDIAN_OF_SAMPLE_SET_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MOS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("median_of_sample_set: assertion failed");
// next-cycle implication
`define MOS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("median_of_sample_set: assertion failed");
`else
`define MOS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define MOS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/mos_pkg.sv
// ----------------------------------------------------------------------------
// mos_pkg
// Shared types and constants for the median-of-sample-set block.
// ----------------------------------------------------------------------------
package mos_pkg;

    localparam int SAMPLE_W        = 32;
    localparam int MAX_SAMPLES_DEF = 64;

    typedef enum logic {
        ST_COLLECT,
        ST_READ
    } t_state;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;    // insert the current sample
        logic shift;  // take the right neighbour's value
    } t_cell_ctrl;

endpackage

FILE: rtl/mos_cell.sv
// ----------------------------------------------------------------------------
// mos_cell
// One slot of the sorting chain: holds a sample, compares, shifts.
// ----------------------------------------------------------------------------
module mos_cell
    import mos_pkg::*;
(
    input  logic                       i_clk,
    input  t_cell_ctrl                 i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_occupied,
    input  logic signed [SAMPLE_W-1:0] i_left_value,
    input  logic                       i_left_gt,
    input  logic signed [SAMPLE_W-1:0] i_right_value,
    output logic signed [SAMPLE_W-1:0] o_value,
    output logic                       o_gt
);

    logic signed [SAMPLE_W-1:0] r_value;
    logic signed [SAMPLE_W-1:0] n_value;

    // empty slot counts as greater: it is where the sample lands
    assign o_gt = !i_occupied || (r_value > i_sample);

    always_comb begin
        n_value = r_value;
        if (i_ctrl.shift) begin
            n_value = i_right_value;
        end else if (i_ctrl.ins && o_gt) begin
            n_value = i_left_gt ? i_left_value : i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: rtl/median_of_sample_set.sv
// ----------------------------------------------------------------------------
// median_of_sample_set
// Median of a streamed set of signed Q16.16 samples via an insertion chain.
// ----------------------------------------------------------------------------
//  channel | valid   | ready   | payload
//  --------+---------+---------+----------------------------------
//  input   | i_valid | o_ready | i_sample, i_last
//  output  | o_valid | i_ready | o_median_value, o_overflow
//
//  While a set is being collected one item is taken every cycle; each cell
//  of the chain compares and shifts in parallel. After the last item of a
//  set with n stored samples the chain is walked towards cell 0, one shift
//  a cycle, to read the middle entries, and no item is taken during the
//  readout. A stalled output holds the readout at its final step. Reset is
//  synchronous active low and clears only control state; no clearing pass
//  is needed.
// ----------------------------------------------------------------------------
`include "median_of_sample_set_assert.svh"

module median_of_sample_set
    import mos_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_median_value,
    output logic                       o_overflow
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    // control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_dropped, n_dropped;
    logic [CNT_W-1:0]  r_idx, n_idx;       // shifts done during readout

    // payload
    logic signed [SAMPLE_W-1:0] r_lo;
    logic signed [SAMPLE_W-1:0] r_median;
    logic                       r_out_ovf;
    logic                       r_out_valid, n_out_valid;

    t_cell_ctrl       cell_ctrl;
    logic             accept;
    logic             full;
    logic             finish;
    logic [CNT_W-1:0] lo_idx, hi_idx;

    logic signed [SAMPLE_W-1:0] cell_value [MAX_SAMPLES];
    logic                       cell_gt    [MAX_SAMPLES];

    logic signed [SAMPLE_W-1:0] lo_value;
    logic signed [SAMPLE_W:0]   mid_sum;

    assign o_ready = (r_state == ST_COLLECT);
    assign accept  = i_valid && o_ready;
    assign full    = (r_count == CNT_W'(MAX_SAMPLES));

    // middle positions of the sorted set
    assign lo_idx = (r_count - CNT_W'(1)) >> 1;
    assign hi_idx = r_count >> 1;

    // readout ends once the upper middle sits in cell 0 and the output is free
    assign finish = (r_state == ST_READ) && (r_idx == hi_idx)
                    && (!r_out_valid || i_ready);

    // ---- the chain ---------------------------------------------------------
    assign cell_ctrl.ins   = accept && !full;
    assign cell_ctrl.shift = (r_state == ST_READ) && (r_idx != hi_idx);

    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        logic signed [SAMPLE_W-1:0] left_value;
        logic                       left_gt;
        logic signed [SAMPLE_W-1:0] right_value;

        if (g == 0) begin : g_first
            assign left_value = i_sample;
            assign left_gt    = 1'b0;
        end else begin : g_inner
            assign left_value = cell_value[g-1];
            assign left_gt    = cell_gt[g-1];
        end

        if (g == MAX_SAMPLES - 1) begin : g_end
            assign right_value = cell_value[g];
        end else begin : g_mid
            assign right_value = cell_value[g+1];
        end

        mos_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (cell_ctrl),
            .i_sample      (i_sample),
            .i_occupied    (r_count > CNT_W'(g)),
            .i_left_value  (left_value),
            .i_left_gt     (left_gt),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_gt          (cell_gt[g])
        );
    end

    // ---- median arithmetic: 33-bit sum, floor halving -----------------------
    assign lo_value = (r_idx == lo_idx) ? cell_value[0] : r_lo;
    assign mid_sum  = {lo_value[SAMPLE_W-1], lo_value}
                    + {cell_value[0][SAMPLE_W-1], cell_value[0]};

    // ---- sequencer ---------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            ST_COLLECT: begin
                if (accept) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last) begin
                        n_idx   = '0;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (finish) begin
                    n_count     = '0;
                    n_dropped   = 1'b0;
                    n_out_valid = 1'b1;
                    n_state     = ST_COLLECT;
                end else if (r_idx != hi_idx) begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ && r_idx == lo_idx) begin
            r_lo <= cell_value[0];
        end
        if (finish) begin
            r_median  <= mid_sum[SAMPLE_W:1];
            r_out_ovf <= r_dropped;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_median_value = r_median;
    assign o_overflow     = r_out_ovf;

    // ---- checks --------------------------------------------------------------
    `MOS_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_SAMPLES))
    `MOS_ASSERT_IMPL(a_no_take_in_read, i_clk, i_rst_n, r_state == ST_READ, !o_ready)
    `MOS_ASSERT_IMPL(a_idx_bound, i_clk, i_rst_n, r_state == ST_READ, r_idx <= hi_idx)
    `MOS_ASSERT_NEXT(a_clear_after, i_clk, i_rst_n, finish, r_count == '0 && !r_dropped && o_valid)

endmodule

FILE: tb/median_of_sample_set_tb.sv
// ----------------------------------------------------------------------------
// median_of_sample_set_tb
// Self-checking bench for the streamed median block. Sets of signed Q16.16
// samples are fed through the valid/ready input; a sorted shadow copy of
// each set predicts the median and the overflow flag, and every result item
// is compared in order. Runs through several sender/receiver idling phases
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module median_of_sample_set_tb;
    import mos_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = MAX_SAMPLES_DEF;
    localparam int PHASE_ITEMS = 150;
    localparam int DRAIN_CYCLES = STORE_DEPTH / 2 + 8;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_sample_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       overflow;
    } t_median;

    // how the samples of one random set are drawn
    typedef enum int {
        FILL_ANY,
        FILL_NEAR_ZERO,
        FILL_EXTREME,
        FILL_MODERATE
    } t_fill_mode;

    logic                       i_clk;
    logic                       i_rst_n   = 1'b0;
    logic                       i_valid   = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample  = '0;
    logic                       i_last    = 1'b0;
    logic                       o_valid;
    logic                       i_ready   = 1'b0;
    logic signed [SAMPLE_W-1:0] o_median_value;
    logic                       o_overflow;

    median_of_sample_set #(
        .MAX_SAMPLES(STORE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_median_value(o_median_value),
        .o_overflow    (o_overflow)
    );

    // Items waiting to be offered, and medians owed by the block, oldest first.
    t_sample_item samples_pending[$];
    t_median      medians_due[$];
    t_sample_item next_item;
    t_median      due;

    // Shadow of the block's sorted store for the set in progress.
    logic signed [SAMPLE_W-1:0] shadow_sorted [0:STORE_DEPTH-1];
    int                         shadow_count = 0;
    logic                       shadow_dropped = 1'b0;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_off = 1'b0;
    logic hold_go = 1'b0;
    int   fail_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Overall watchdog; the slowest legal run is a small fraction of this.
    initial begin
        #3_600_000;
        $display("** median_of_sample_set: FAILED **");
        $finish;
    end

    // Insert one accepted sample into the shadow store; on the closing item
    // work out the median and queue it, then start a fresh set.
    task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] s, input logic is_last);
        int                  pos;
        logic [SAMPLE_W:0]   pair_sum;
        t_median             m;
        if (shadow_count >= STORE_DEPTH) begin
            // store full: sample is lost, flag sticks until the set closes
            shadow_dropped = 1'b1;
        end else begin
            pos = shadow_count;
            // equal samples stay ahead of the newcomer
            while (pos > 0 && shadow_sorted[pos-1] > s) pos--;
            for (int k = shadow_count; k > pos; k--) shadow_sorted[k] = shadow_sorted[k-1];
            shadow_sorted[pos] = s;
            shadow_count++;
        end
        if (is_last) begin
            if (shadow_count % 2 == 1) begin
                m.value = shadow_sorted[(shadow_count - 1) / 2];
            end else begin
                // 33-bit sum, arithmetic halving: rounds toward minus infinity
                pair_sum = {shadow_sorted[shadow_count/2][SAMPLE_W-1],
                            shadow_sorted[shadow_count/2]}
                         + {shadow_sorted[shadow_count/2-1][SAMPLE_W-1],
                            shadow_sorted[shadow_count/2-1]};
                m.value = pair_sum[SAMPLE_W:1];
            end
            m.overflow = shadow_dropped;
            medians_due = {medians_due, m};
            shadow_count = 0;
            shadow_dropped = 1'b0;
        end
    endtask

    // Sender: offers the next pending item whenever the previous one has gone
    // and the idling dice allow; the payload is held until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                absorb_sample(i_sample, i_last);
            end
            if (!i_valid || o_ready) begin
                if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = samples_pending.pop_front();
                    i_valid  <= 1'b1;
                    i_sample <= next_item.sample;
                    i_last   <= next_item.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each taken result against the oldest owed median.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (medians_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got value %0d overflow %0b",
                             $time, o_median_value, o_overflow);
                end else begin
                    due = medians_due.pop_front();
                    if (o_median_value !== due.value) begin
                        fail_count++;
                        $display("%0t: median_value mismatch, expected %0d got %0d",
                                 $time, $signed(due.value), o_median_value);
                    end
                    if (o_overflow !== due.overflow) begin
                        fail_count++;
                        $display("%0t: overflow mismatch, expected %0b got %0b",
                                 $time, due.overflow, o_overflow);
                    end
                end
            end
            i_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off: the sender keeps going, so the block must
    // back up behind an unread median and stall its input.
    initial begin
        while (!hold_go) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] s, input logic is_last);
        t_sample_item it;
        it.sample = s;
        it.last   = is_last;
        samples_pending = {samples_pending, it};
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample(input t_fill_mode mode);
        case (mode)
            FILL_NEAR_ZERO: return int'($urandom_range(16)) - 8;
            FILL_EXTREME: begin
                if ($urandom_range(1) == 1) return S_MAX - int'($urandom_range(3));
                return S_MIN + int'($urandom_range(3));
            end
            // within about +/-1000.0 in Q16.16
            FILL_MODERATE: return int'($urandom_range(131_072_000)) - 65_536_000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random_set(input int len);
        t_fill_mode mode;
        mode = t_fill_mode'($urandom_range(3));
        for (int k = 0; k < len; k++) queue_sample(draw_sample(mode), k == len - 1);
    endtask

    // Mostly short sets, some medium, a few that run past the store size.
    task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
        int queued;
        int len;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queued = 0;
        while (queued < quota) begin
            pick = $urandom_range(99);
            if (pick < 70)      len = $urandom_range(8, 1);
            else if (pick < 95) len = $urandom_range(40, 9);
            else                len = $urandom_range(STORE_DEPTH + 6, STORE_DEPTH - 4);
            queue_random_set(len);
            queued += len;
        end
        while (samples_pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sets: single extremes, 33-bit sums at both rails,
        // floor rounding of negative halves, equal samples, odd/even counts.
        queue_sample(S_MAX, 1'b1);
        queue_sample(S_MIN, 1'b1);
        queue_sample(S_MAX, 1'b0); queue_sample(S_MAX, 1'b1);
        queue_sample(S_MIN, 1'b0); queue_sample(S_MIN, 1'b1);
        queue_sample(S_MAX, 1'b0); queue_sample(S_MIN, 1'b1);
        queue_sample(-1, 1'b0);    queue_sample(0, 1'b1);
        queue_sample(2, 1'b0);     queue_sample(1, 1'b1);
        queue_sample(5, 1'b0);     queue_sample(5, 1'b0);     queue_sample(5, 1'b1);
        queue_sample(7, 1'b0);     queue_sample(3, 1'b0);     queue_sample(0, 1'b0);
        queue_sample(-3, 1'b0);    queue_sample(-7, 1'b1);
        queue_sample(32'sh0001_0000, 1'b0); queue_sample(32'shFFFF_0000, 1'b0);
        queue_sample(32'sh7FFF_0000, 1'b0); queue_sample(32'sh8001_0000, 1'b1);

        // Store exactly full, then one and two past full (the closing
        // sample itself is dropped in the first of those).
        queue_random_set(STORE_DEPTH);
        queue_random_set(STORE_DEPTH + 1);
        queue_random_set(STORE_DEPTH + 2);

        hold_go = 1'b1;
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(47, 0, PHASE_ITEMS);
        run_phase(0, 47, PHASE_ITEMS);
        run_phase(25, 25, PHASE_ITEMS);

        while (samples_pending.size() != 0 || i_valid || medians_due.size() != 0)
            @(posedge i_clk);
        // catch any stray result after the last owed one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("** median_of_sample_set: PASSED **");
        end else begin
            $display("** median_of_sample_set: FAILED **");
        end
        $finish;
    end

endmodule
